// ----- hdl/button_gesture_classifier_top_macros.svh -----
// Assertion macros shared by the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// Condition must hold on every clock outside reset.
`define BGC_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent on one clock implies consequent on the next.
`define BGC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bgc_pkg.sv -----
package bgc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int MAX_CLICKS_DEF  = 4;

  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

  // Gesture codes.
  localparam logic [CODE_W-1:0] CODE_SINGLE = 3'd0;
  localparam logic [CODE_W-1:0] CODE_DOUBLE = 3'd1;
  localparam logic [CODE_W-1:0] CODE_TRIPLE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_QUAD   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_LONG   = 3'd4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd800;
  localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd400;

  // One gesture result handed from the front to the queue.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

// ----- hdl/bgc_front.sv -----
module bgc_front #(
  parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF,
  parameter int MAX_CLICKS  = bgc_pkg::MAX_CLICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          raw_pressed,
  input  logic                          cfg_write,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_W-1:0]     cfg_data,
  output bgc_pkg::result_t              result
);

  localparam int CT_W  = $clog2(MAX_CLICKS + 1);
  localparam int CMP_W = (TIMER_WIDTH > bgc_pkg::CFG_W) ? TIMER_WIDTH : bgc_pkg::CFG_W;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_WAITING = 2'd2;
  localparam logic [1:0] PH_RELWAIT = 2'd3;

  logic [bgc_pkg::CFG_W-1:0] debounce_len;
  logic [bgc_pkg::CFG_W-1:0] long_press_ticks;
  logic [bgc_pkg::CFG_W-1:0] click_window_len;

  logic [1:0]             phase, phase_next;
  logic                   previous_raw;
  logic [TIMER_WIDTH-1:0] debounce_count, debounce_count_next;
  logic                   debounce_running, debounce_running_next;
  logic                   recheck_pending, recheck_pending_next;
  logic [TIMER_WIDTH-1:0] held_count, held_count_next;
  logic [TIMER_WIDTH-1:0] window_count, window_count_next;
  logic [CT_W-1:0]        click_total, click_total_next;

  logic                   sample;
  logic [TIMER_WIDTH-1:0] debounce_load;
  logic [TIMER_WIDTH-1:0] held_inc;
  logic [TIMER_WIDTH-1:0] window_inc;
  logic [2:0]             total3;
  logic [bgc_pkg::CODE_W-1:0] click_code;
  bgc_pkg::result_t       result_next;

  assign debounce_load = TIMER_WIDTH'(debounce_len);
  assign held_inc   = (held_count == '1) ? held_count : held_count + 1'b1;
  assign window_inc = (window_count == '1) ? window_count : window_count + 1'b1;
  assign total3     = 3'(click_total);

  always_comb begin
    if (total3 >= 3'd4) begin
      click_code = bgc_pkg::CODE_QUAD;
    end else if (total3 == 3'd0) begin
      click_code = bgc_pkg::CODE_SINGLE;
    end else begin
      click_code = total3 - 3'd1;
    end
  end

  // Debounce timer: edge detect, then count down and sample at zero.
  always_comb begin
    debounce_running_next = debounce_running;
    debounce_count_next   = debounce_count;
    recheck_pending_next  = recheck_pending;
    sample                = 1'b0;
    if (raw_pressed != previous_raw) begin
      if (debounce_running) begin
        recheck_pending_next = 1'b1;
      end else begin
        debounce_running_next = 1'b1;
        debounce_count_next   = debounce_load;
      end
    end
    if (debounce_running_next) begin
      if (debounce_count_next == '0) begin
        sample = 1'b1;
        if (recheck_pending_next) begin
          recheck_pending_next = 1'b0;
          debounce_count_next  = debounce_load;
        end else begin
          debounce_running_next = 1'b0;
        end
      end else begin
        debounce_count_next = debounce_count_next - 1'b1;
      end
    end
  end

  // Gesture phase machine.
  always_comb begin
    phase_next        = phase;
    held_count_next   = held_count;
    window_count_next = window_count;
    click_total_next  = click_total;
    result_next       = '0;
    unique case (phase)
      PH_IDLE: begin
        if (sample && raw_pressed) begin
          phase_next       = PH_PRESSED;
          held_count_next  = '0;
          click_total_next = '0;
        end
      end
      PH_PRESSED: begin
        held_count_next = held_inc;
        if (CMP_W'(held_inc) >= CMP_W'(long_press_ticks)) begin
          result_next.valid = 1'b1;
          result_next.code  = bgc_pkg::CODE_LONG;
          phase_next        = PH_RELWAIT;
          click_total_next  = '0;
        end else if (sample && !raw_pressed) begin
          if (click_total < CT_W'(MAX_CLICKS)) begin
            click_total_next = click_total + 1'b1;
          end
          phase_next        = PH_WAITING;
          window_count_next = '0;
        end
      end
      PH_WAITING: begin
        if (sample && raw_pressed) begin
          phase_next      = PH_PRESSED;
          held_count_next = '0;
        end else begin
          window_count_next = window_inc;
          if (CMP_W'(window_inc) >= CMP_W'(click_window_len)) begin
            result_next.valid = 1'b1;
            result_next.code  = click_code;
            phase_next        = PH_IDLE;
            click_total_next  = '0;
          end
        end
      end
      PH_RELWAIT: begin
        if (sample && !raw_pressed) begin
          phase_next       = PH_IDLE;
          click_total_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_len     <= bgc_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bgc_pkg::LONG_RESET;
      click_window_len <= bgc_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bgc_pkg::REG_DEBOUNCE: debounce_len     <= cfg_data;
        bgc_pkg::REG_LONG:     long_press_ticks <= cfg_data;
        bgc_pkg::REG_WINDOW:   click_window_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      previous_raw     <= 1'b0;
      debounce_count   <= '0;
      debounce_running <= 1'b0;
      recheck_pending  <= 1'b0;
      held_count       <= '0;
      window_count     <= '0;
      click_total      <= '0;
    end else if (tick) begin
      phase            <= phase_next;
      previous_raw     <= raw_pressed;
      debounce_count   <= debounce_count_next;
      debounce_running <= debounce_running_next;
      recheck_pending  <= recheck_pending_next;
      held_count       <= held_count_next;
      window_count     <= window_count_next;
      click_total      <= click_total_next;
    end
  end

  assign result.valid = tick && result_next.valid;
  assign result.code  = result_next.code;

`include "button_gesture_classifier_top_macros.svh"

  `BGC_ASSERT_NEXT(a_long_enters_relwait, clk, rst, result.valid && (result.code == bgc_pkg::CODE_LONG), phase == PH_RELWAIT, "long press did not enter release wait")
  `BGC_ASSERT_ALWAYS(a_clicks_bounded, clk, rst, click_total <= CT_W'(MAX_CLICKS), "click total above limit")

endmodule

// ----- hdl/bgc_queue.sv -----
module bgc_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  bgc_pkg::result_t           push,
  input  logic                       pop,
  output logic                       full,
  output logic                       not_empty,
  output logic [bgc_pkg::CODE_W-1:0] head_code
);

  localparam int DEPTH = bgc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [bgc_pkg::CODE_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_code = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "button_gesture_classifier_top_macros.svh"

  `BGC_ASSERT_ALWAYS(a_no_push_when_full, clk, rst, !(push.valid && full), "push into full queue")
  `BGC_ASSERT_NEXT(a_pop_drains, clk, rst, do_pop && !push.valid, count == ($past(count) - CNT_W'(1)), "pop did not drain an entry")

endmodule

// ----- hdl/bgc_back.sv -----
module bgc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic [bgc_pkg::CODE_W-1:0] q_code,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bgc_pkg::CODE_W-1:0] gesture_code
);

  logic take;

  // Reload the output register when it is empty or its beat leaves now.
  assign take = !out_valid || !out_stall;
  assign pop  = take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      gesture_code <= q_code;
    end
  end

endmodule

// ----- hdl/button_gesture_classifier_top.sv -----
// Button gesture classifier. Each input beat is one tick carrying the raw
// button level (raw_pressed, 1 = pressed). A level change starts a debounce
// timer loaded from the debounce register; the level is sampled when it
// expires, and an edge seen during the wait re-arms one more wait. A qualified
// press that is held for the long-press count yields gesture_code 4 (long) at
// once, then the block waits silently for release. Short presses are counted
// (saturating at MAX_CLICKS); once the multi-click window passes after a
// release with no new press, the block yields 0 single, 1 double, 2 triple or
// 3 quad-or-more. A tick yields zero or one output beat. Throughput is one
// tick per clock: the tick front end updates its counters and phase on each
// accepted tick, and results pass through a two-entry queue to a registered
// output stage, so in_stall rises only when that queue is full because
// out_stall has held results back. A result is written into the queue on
// the edge that accepts its tick, and out_valid is registered from the queue.
// Registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0 debounce, 1 long press, 2 multi-click window; index 3 is
// ignored. Write them only while the block is idle.
module button_gesture_classifier_top #(
  parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF,
  parameter int MAX_CLICKS  = bgc_pkg::MAX_CLICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          raw_pressed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bgc_pkg::CODE_W-1:0]    gesture_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_W-1:0]     cfg_data
);

  logic                       tick;
  bgc_pkg::result_t           result;
  logic                       q_full;
  logic                       q_valid;
  logic [bgc_pkg::CODE_W-1:0] q_code;
  logic                       pop;

  // Hold the tick stream only when no room is left for a result.
  assign in_stall  = q_full;
  assign tick      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  bgc_front #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .MAX_CLICKS  (MAX_CLICKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .raw_pressed (raw_pressed),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result      (result)
  );

  // Decouple result production from the output handshake.
  bgc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_code (q_code)
  );

  // Drive the registered output beat.
  bgc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_code       (q_code),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gesture_code (gesture_code)
  );

endmodule
